/* hw/rtl/parity_framed_prefix_code_decoder_macros.svh */
// assertion macros shared by the decoder rtl
`ifndef PARITY_FRAMED_PREFIX_CODE_DECODER_MACROS_SVH
`define PARITY_FRAMED_PREFIX_CODE_DECODER_MACROS_SVH

// same-cycle implication on clk, disabled while rst_n is low
`define PFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, disabled while rst_n is low
`define PFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pfpcd_pkg.sv */
// types and constants of the parity framed prefix code decoder
package pfpcd_pkg;

  // request kinds
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_HEX    = 2'd2;

  // frame layout: eight data bits, then one parity bit
  localparam int FRAME_DATA_BITS = 8;
  // width of the code bits field
  localparam int CODE_FIELD_BITS = 16;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_LINK,
    ST_INS_SYM,
    ST_HEX_BIT,
    ST_WK_RD,
    ST_WK_CHK,
    ST_WK_END
  } pfd_state_t;

endpackage

/* hw/rtl/parity_framed_prefix_code_decoder.sv */
// parity framed prefix code tree decoder: sequencer, node tables and output register
//
//  channel  | ports                                             | dir | flow
//  ---------+---------------------------------------------------+-----+-------------
//  in       | in_valid in_stall in_req_type in_hex_digit         | in  | valid/stall
//           | in_code_bits in_code_length in_code_symbol         |     |
//  out      | out_valid out_stall out_symbol out_last            | out | valid/stall
//           | out_table_full                                     |     |
//  cfg      | cfg_valid cfg_ready cfg_data (max_symbols)         | in  | valid/ready
//
// every beat is accepted in ST_IDLE; clear, unknown and zero-length inserts end there
// an insert then steps ST_INS_RD and ST_INS_CHK per code bit, ST_INS_LINK per new node
// and ST_INS_SYM stores the symbol; an insert that runs out of nodes stops at that bit
// a hex beat then steps ST_HEX_BIT once per bit; a frame that passes parity adds
// ST_WK_RD (node read) and ST_WK_CHK (child select) per data bit, ST_WK_END to close
// the tree node tables share one registered read port; the root lives in flops
// so reset and clear need no clearing pass; other nodes are written on allocation
// a stalled output holds the walk when a second symbol needs the output register
module parity_framed_prefix_code_decoder import pfpcd_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int CODE_MAX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_hex_digit,
  input  logic [15:0] in_code_bits,
  input  logic [4:0]  in_code_length,
  input  logic [7:0]  in_code_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic        out_last,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "parity_framed_prefix_code_decoder_macros.svh"

  localparam int NW     = $clog2(NODE_COUNT);
  localparam int LCLOG  = $clog2(CODE_MAX_BITS + 1);
  localparam int LW     = (LCLOG > 5) ? LCLOG : 5;
  localparam logic [NW:0] NODE_LIM = (NW+1)'(NODE_COUNT);

  // control state
  pfd_state_t     state_r, state_nxt;
  logic [15:0]    max_sym_r, max_sym_nxt;
  logic [NW:0]    nfree_r, nfree_nxt;
  logic [NW-1:0]  cur_r, cur_nxt;
  logic [7:0]     frame_r, frame_nxt;
  logic [3:0]     fpos_r, fpos_nxt;
  logic [15:0]    emitted_r, emitted_nxt;
  logic           ovf_r, ovf_nxt;
  logic [NW-1:0]  root_zero_r, root_zero_nxt;
  logic [NW-1:0]  root_one_r, root_one_nxt;
  logic [7:0]     root_sym_r, root_sym_nxt;
  logic           wpend_r, wpend_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic           out_valid_r, out_valid_nxt;

  // payload state
  logic [15:0]    code_bits_r, code_bits_nxt;
  logic [7:0]     code_sym_r, code_sym_nxt;
  logic [LW-1:0]  ilen_r, ilen_nxt;
  logic [NW-1:0]  node_r, node_nxt;
  logic [NW-1:0]  new_node_r, new_node_nxt;
  logic           link_bit_r, link_bit_nxt;
  logic [3:0]     hex_r, hex_nxt;
  logic [1:0]     hbit_r, hbit_nxt;
  logic [7:0]     wdata_r, wdata_nxt;
  logic [2:0]     wbit_r, wbit_nxt;
  logic [7:0]     pend_sym_r, pend_sym_nxt;
  logic [7:0]     out_sym_r, out_sym_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_tf_r, out_tf_nxt;

  // node tables
  logic [NW-1:0]  mem_zero [NODE_COUNT];
  logic [NW-1:0]  mem_one  [NODE_COUNT];
  logic [7:0]     mem_sym  [NODE_COUNT];
  logic [NW-1:0]  rd_zero_r, rd_one_r;
  logic [7:0]     rd_sym_r;
  logic [NW-1:0]  rd_addr;
  logic           mz_we, mo_we, ms_we;
  logic [NW-1:0]  mz_addr, mo_addr, ms_addr;
  logic [NW-1:0]  mz_data, mo_data;
  logic [7:0]     ms_data;

  // helpers
  logic           in_acc, clr_acc, out_free, out_load;
  logic [LW-1:0]  bidx;
  logic           ins_bit, hex_b, wk_b, emit;
  logic [NW-1:0]  slot, base, cz, co, nx;
  logic [NW-1:0]  iz, io;
  logic [7:0]     cur_sym;
  logic [NW:0]    node_ext, cur_ext;
  logic           cnt_hold;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign clr_acc   = in_acc && (in_req_type == REQ_CLEAR);
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_symbol     = out_sym_r;
  assign out_last       = out_last_r;
  assign out_table_full = out_tf_r;

  // table read address: insert walk uses node_r, decode walk uses cur_r
  assign rd_addr = (state_r inside {ST_INS_RD, ST_INS_CHK, ST_INS_LINK, ST_INS_SYM})
                   ? node_r : cur_r;

  // insert code bit, bits above the field read as zero
  assign bidx    = LW'(ilen_r - LW'(1));
  assign ins_bit = (bidx < LW'(CODE_FIELD_BITS)) ? code_bits_r[bidx[3:0]] : 1'b0;
  assign iz      = (node_r == '0) ? root_zero_r : rd_zero_r;
  assign io      = (node_r == '0) ? root_one_r : rd_one_r;
  assign slot    = ins_bit ? io : iz;

  // decode walk step
  assign hex_b   = hex_r[hbit_r];
  assign wk_b    = wdata_r[wbit_r];
  assign cur_sym = (cur_r == '0) ? root_sym_r : rd_sym_r;
  assign emit    = (cur_sym != 8'd0) && (emitted_r < max_sym_r);
  assign base    = emit ? '0 : cur_r;
  assign cz      = (base == '0) ? root_zero_r : rd_zero_r;
  assign co      = (base == '0) ? root_one_r : rd_one_r;
  assign nx      = wk_b ? co : cz;

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    max_sym_nxt   = max_sym_r;
    nfree_nxt     = nfree_r;
    cur_nxt       = cur_r;
    frame_nxt     = frame_r;
    fpos_nxt      = fpos_r;
    emitted_nxt   = emitted_r;
    ovf_nxt       = ovf_r;
    root_zero_nxt = root_zero_r;
    root_one_nxt  = root_one_r;
    root_sym_nxt  = root_sym_r;
    wpend_nxt     = wpend_r;
    pend_v_nxt    = pend_v_r;
    code_bits_nxt = code_bits_r;
    code_sym_nxt  = code_sym_r;
    ilen_nxt      = ilen_r;
    node_nxt      = node_r;
    new_node_nxt  = new_node_r;
    link_bit_nxt  = link_bit_r;
    hex_nxt       = hex_r;
    hbit_nxt      = hbit_r;
    wdata_nxt     = wdata_r;
    wbit_nxt      = wbit_r;
    pend_sym_nxt  = pend_sym_r;
    out_load      = 1'b0;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_tf_nxt    = out_tf_r;
    mz_we = 1'b0; mo_we = 1'b0; ms_we = 1'b0;
    mz_addr = node_r; mo_addr = node_r; ms_addr = node_r;
    mz_data = new_node_r; mo_data = new_node_r; ms_data = code_sym_r;

    // config write
    if (cfg_valid && cfg_ready) begin
      max_sym_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            REQ_CLEAR: begin
              nfree_nxt     = (NW+1)'(1);
              cur_nxt       = '0;
              frame_nxt     = 8'd0;
              fpos_nxt      = 4'd0;
              emitted_nxt   = 16'd0;
              ovf_nxt       = 1'b0;
              root_zero_nxt = '0;
              root_one_nxt  = '0;
              root_sym_nxt  = 8'd0;
            end
            REQ_INSERT: begin
              code_bits_nxt = in_code_bits;
              code_sym_nxt  = in_code_symbol;
              ilen_nxt      = (LW'(in_code_length) > LW'(CODE_MAX_BITS))
                              ? LW'(CODE_MAX_BITS) : LW'(in_code_length);
              node_nxt      = '0;
              if (in_code_length != 5'd0) begin
                state_nxt = ST_INS_RD;
              end
            end
            REQ_HEX: begin
              hex_nxt   = in_hex_digit;
              hbit_nxt  = 2'd3;
              wpend_nxt = 1'b0;
              state_nxt = ST_HEX_BIT;
            end
            default: begin
            end
          endcase
        end
      end

      // read the node's children
      ST_INS_RD: begin
        state_nxt = ST_INS_CHK;
      end

      // follow the child or allocate a fresh node
      ST_INS_CHK: begin
        if (slot == '0) begin
          if (nfree_r >= (NW+1)'(NODE_COUNT)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            new_node_nxt = nfree_r[NW-1:0];
            link_bit_nxt = ins_bit;
            nfree_nxt    = nfree_r + (NW+1)'(1);
            mz_we = 1'b1; mo_we = 1'b1; ms_we = 1'b1;
            mz_addr = nfree_r[NW-1:0];
            mo_addr = nfree_r[NW-1:0];
            ms_addr = nfree_r[NW-1:0];
            mz_data = '0; mo_data = '0; ms_data = 8'd0;
            state_nxt = ST_INS_LINK;
          end
        end else begin
          node_nxt  = slot;
          ilen_nxt  = bidx;
          state_nxt = (ilen_r == LW'(1)) ? ST_INS_SYM : ST_INS_RD;
        end
      end

      // hook the new node under its parent
      ST_INS_LINK: begin
        if (node_r == '0) begin
          if (link_bit_r) root_one_nxt = new_node_r;
          else            root_zero_nxt = new_node_r;
        end else begin
          mz_we = !link_bit_r;
          mo_we = link_bit_r;
        end
        node_nxt  = new_node_r;
        ilen_nxt  = bidx;
        state_nxt = (ilen_r == LW'(1)) ? ST_INS_SYM : ST_INS_RD;
      end

      // store the symbol at the end of the code
      ST_INS_SYM: begin
        if (node_r == '0) root_sym_nxt = code_sym_r;
        else              ms_we = 1'b1;
        state_nxt = ST_IDLE;
      end

      // framing, one bit a cycle
      ST_HEX_BIT: begin
        if (fpos_r < 4'(FRAME_DATA_BITS)) begin
          frame_nxt = {frame_r[6:0], hex_b};
          fpos_nxt  = fpos_r + 4'd1;
        end else begin
          if ((^frame_r) ^ hex_b) begin
            wpend_nxt = 1'b1;
            wdata_nxt = frame_r;
          end
          frame_nxt = 8'd0;
          fpos_nxt  = 4'd0;
        end
        hbit_nxt = hbit_r - 2'd1;
        if (hbit_r == 2'd0) begin
          wbit_nxt  = 3'd7;
          state_nxt = wpend_nxt ? ST_WK_RD : ST_IDLE;
        end
      end

      // read the current node
      ST_WK_RD: begin
        state_nxt = ST_WK_CHK;
      end

      // emit if a symbol sits here and the symbol limit is not reached, then take the bit
      ST_WK_CHK: begin
        if (!(emit && pend_v_r && !out_free)) begin
          if (emit) begin
            if (pend_v_r) begin
              out_load     = 1'b1;
              out_sym_nxt  = pend_sym_r;
              out_last_nxt = 1'b0;
              out_tf_nxt   = ovf_r;
            end
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = cur_sym;
            emitted_nxt  = emitted_r + 16'd1;
          end
          cur_nxt   = (nx != '0) ? nx : base;
          wbit_nxt  = wbit_r - 3'd1;
          state_nxt = (wbit_r == 3'd0) ? ST_WK_END : ST_WK_RD;
        end
      end

      // flush the held symbol as the final one of this beat
      ST_WK_END: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_sym_nxt  = pend_sym_r;
          out_last_nxt = 1'b1;
          out_tf_nxt   = ovf_r;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_sym_r   <= 16'd0;
      nfree_r     <= (NW+1)'(1);
      cur_r       <= '0;
      frame_r     <= 8'd0;
      fpos_r      <= 4'd0;
      emitted_r   <= 16'd0;
      ovf_r       <= 1'b0;
      root_zero_r <= '0;
      root_one_r  <= '0;
      root_sym_r  <= 8'd0;
      wpend_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_sym_r   <= max_sym_nxt;
      nfree_r     <= nfree_nxt;
      cur_r       <= cur_nxt;
      frame_r     <= frame_nxt;
      fpos_r      <= fpos_nxt;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      root_zero_r <= root_zero_nxt;
      root_one_r  <= root_one_nxt;
      root_sym_r  <= root_sym_nxt;
      wpend_r     <= wpend_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_bits_r <= code_bits_nxt;
    code_sym_r  <= code_sym_nxt;
    ilen_r      <= ilen_nxt;
    node_r      <= node_nxt;
    new_node_r  <= new_node_nxt;
    link_bit_r  <= link_bit_nxt;
    hex_r       <= hex_nxt;
    hbit_r      <= hbit_nxt;
    wdata_r     <= wdata_nxt;
    wbit_r      <= wbit_nxt;
    pend_sym_r  <= pend_sym_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_tf_r    <= out_tf_nxt;
  end

  // node tables, one write port each, shared registered read port
  always_ff @(posedge clk) begin
    if (mz_we) mem_zero[mz_addr] <= mz_data;
    if (mo_we) mem_one[mo_addr]  <= mo_data;
    if (ms_we) mem_sym[ms_addr]  <= ms_data;
    rd_zero_r <= mem_zero[rd_addr];
    rd_one_r  <= mem_one[rd_addr];
    rd_sym_r  <= mem_sym[rd_addr];
  end

  // check terms
  assign node_ext = (NW+1)'(node_r);
  assign cur_ext  = (NW+1)'(cur_r);
  assign cnt_hold = (state_r != ST_WK_CHK) && !clr_acc;

  // checks
  `PFD_ASSERT_IMPL(a_nfree_range, 1'b1, (nfree_r != '0) && (nfree_r <= NODE_LIM), "free ptr range")
  `PFD_ASSERT_IMPL(a_idle_no_pend, state_r == ST_IDLE, !pend_v_r, "held symbol left at idle")
  `PFD_ASSERT_IMPL(a_ins_node_alloc, state_r == ST_INS_RD, node_ext < nfree_r, "bad insert node")
  `PFD_ASSERT_IMPL(a_wk_node_alloc, state_r == ST_WK_RD, cur_ext < nfree_r, "bad walk node")
  `PFD_ASSERT_NEXT(a_emit_only_walk, cnt_hold, $stable(emitted_r), "count moved off walk")

endmodule
